>>> src/srae_pkg.sv
// ----------------------------------------------------------------------------
// srae_pkg
// Shared constants, codes and types of the serial register access engine.
// ----------------------------------------------------------------------------
`default_nettype none

package srae_pkg;

  localparam int MAP_BYTES        = 512;
  localparam int ADDR_W           = $clog2(MAP_BYTES);
  localparam int BYTES_PER_RESULT = 8;
  localparam int FILL_W           = $clog2(BYTES_PER_RESULT + 1);
  localparam int LANE_W           = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
  localparam int OUT_W            = 64;
  localparam int COUNT_W          = 4;
  localparam int HDR_LEN          = 5;
  localparam int HDR_CNT_W        = 3;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CMD_WRITE    = 8'hF0;
  localparam logic [7:0] CMD_READ     = 8'hF1;
  localparam logic [7:0] ANS_WRITE_OK = 8'hFB;
  localparam logic [7:0] ANS_READ     = 8'hFC;
  localparam logic [7:0] ANS_ERROR    = 8'hFF;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_REPLY,
    OP_READ
  } op_t;

  // STORE: addr/data to write, reply set on the final byte of a write.
  // REPLY: data is the answer byte. READ: addr is start, data is length.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              reply;
  } job_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

>>> src/srae_req_if.sv
// ----------------------------------------------------------------------------
// srae_req_if
// Request channel: received bytes and timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

interface srae_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> src/srae_rsp_if.sv
// ----------------------------------------------------------------------------
// srae_rsp_if
// Response channel: packed answer bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface srae_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [srae_pkg::OUT_W-1:0]    out_bytes;
  logic [srae_pkg::COUNT_W-1:0]  byte_count;
  logic                          last;

  modport source (output valid, output out_bytes, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input out_bytes, input byte_count, input last,
                  output ready);
endinterface

`default_nettype wire

>>> src/srae_front.sv
// ----------------------------------------------------------------------------
// srae_front
// Header parser: tracks header and write phase, turns transactions into jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module srae_front (
  input  wire                    clk,
  input  wire                    rst,
  srae_req_if.sink               req,
  input  wire                    q_full,
  input  srae_pkg::back_status_t status,
  output logic                   push,
  output srae_pkg::job_t         push_job
);

  logic                              phase, phase_next;
  logic [srae_pkg::HDR_CNT_W-1:0]    header_count, header_count_next;
  logic [7:0]                        command_byte, command_byte_next;
  logic [7:0]                        start_offset, start_offset_next;
  logic [7:0]                        write_remaining, write_remaining_next;
  logic [srae_pkg::ADDR_W-1:0]       write_address, write_address_next;
  logic                              accept;

  assign req.ready = !q_full && !status.clearing;
  assign accept    = req.valid && req.ready;

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    command_byte_next    = command_byte;
    start_offset_next    = start_offset;
    write_remaining_next = write_remaining;
    write_address_next   = write_address;
    push                 = 1'b0;
    push_job             = '0;
    if (accept) begin
      if (phase) begin
        if (req.kind) begin
          push                 = 1'b1;
          push_job.op          = srae_pkg::OP_REPLY;
          push_job.data        = srae_pkg::ANS_ERROR;
          phase_next           = 1'b0;
          header_count_next    = '0;
          write_remaining_next = '0;
        end else begin
          push           = 1'b1;
          push_job.op    = srae_pkg::OP_STORE;
          push_job.addr  = write_address;
          push_job.data  = req.rx_byte;
          push_job.reply = (write_remaining == 8'd1);
          if (write_address == srae_pkg::ADDR_W'(srae_pkg::MAP_BYTES - 1)) begin
            write_address_next = '0;
          end else begin
            write_address_next = write_address + 1'b1;
          end
          write_remaining_next = write_remaining - 8'd1;
          if (write_remaining == 8'd1) begin
            phase_next        = 1'b0;
            header_count_next = '0;
          end
        end
      end else if (!req.kind) begin
        if (header_count == srae_pkg::HDR_CNT_W'(0)) begin
          command_byte_next = req.rx_byte;
        end
        if (header_count == srae_pkg::HDR_CNT_W'(1)) begin
          start_offset_next = req.rx_byte;
        end
        if (header_count != srae_pkg::HDR_CNT_W'(srae_pkg::HDR_LEN - 1)) begin
          header_count_next = header_count + 1'b1;
        end else begin
          header_count_next = '0;
          if (command_byte == srae_pkg::CMD_WRITE) begin
            if (req.rx_byte == 8'd0) begin
              push          = 1'b1;
              push_job.op   = srae_pkg::OP_REPLY;
              push_job.data = srae_pkg::ANS_WRITE_OK;
            end else begin
              phase_next           = 1'b1;
              write_remaining_next = req.rx_byte;
              write_address_next   = srae_pkg::ADDR_W'(start_offset);
            end
          end else if (command_byte == srae_pkg::CMD_READ) begin
            push          = 1'b1;
            push_job.op   = srae_pkg::OP_READ;
            push_job.addr = srae_pkg::ADDR_W'(start_offset);
            push_job.data = req.rx_byte;
          end else begin
            push          = 1'b1;
            push_job.op   = srae_pkg::OP_REPLY;
            push_job.data = srae_pkg::ANS_ERROR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= 1'b0;
      header_count    <= '0;
      command_byte    <= '0;
      start_offset    <= '0;
      write_remaining <= '0;
      write_address   <= '0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      command_byte    <= command_byte_next;
      start_offset    <= start_offset_next;
      write_remaining <= write_remaining_next;
      write_address   <= write_address_next;
    end
  end

endmodule

`default_nettype wire

>>> src/srae_queue.sv
// ----------------------------------------------------------------------------
// srae_queue
// Small job FIFO between parser and executor.
// ----------------------------------------------------------------------------
`default_nettype none

module srae_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  srae_pkg::job_t        push_job,
  input  wire                   pop,
  output logic                  q_valid,
  output srae_pkg::job_t        head,
  output logic                  q_full
);

  srae_pkg::job_t                slots [srae_pkg::QUEUE_DEPTH];
  logic [srae_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [srae_pkg::QCNT_W-1:0]   count;

  assign q_valid = (count != '0);
  assign q_full  = (count == srae_pkg::QCNT_W'(srae_pkg::QUEUE_DEPTH));
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srae_pkg::QPTR_W'(srae_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srae_pkg::QPTR_W'(srae_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!q_full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> src/srae_back.sv
// ----------------------------------------------------------------------------
// srae_back
// Executor: owns the byte map, clears it after reset, performs stores,
// streams read bursts and holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module srae_back (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     q_valid,
  input  srae_pkg::job_t          head,
  output logic                    pop,
  output srae_pkg::back_status_t  status,
  srae_rsp_if.source              rsp
);

  localparam int BPR = srae_pkg::BYTES_PER_RESULT;

  logic [7:0]                        map_mem [srae_pkg::MAP_BYTES];

  srae_pkg::back_state_t             state, state_next;
  logic [srae_pkg::ADDR_W-1:0]       clr_addr, clr_addr_next;
  logic [BPR-1:0][7:0]               acc, acc_next;
  logic [srae_pkg::FILL_W-1:0]       fill, fill_next;
  logic [7:0]                        rem, rem_next;
  logic [srae_pkg::ADDR_W-1:0]       raddr, raddr_next;
  logic                              pend, pend_next;
  logic [7:0]                        rd_data;

  logic                              out_valid, out_valid_next;
  logic [srae_pkg::OUT_W-1:0]        out_bytes, out_bytes_next;
  logic [srae_pkg::COUNT_W-1:0]      out_count, out_count_next;
  logic                              out_last, out_last_next;

  logic                              out_free;
  logic                              mem_we;
  logic [srae_pkg::ADDR_W-1:0]       mem_waddr;
  logic [7:0]                        mem_wdata;
  logic                              rd_issue;
  logic                              take;
  logic                              flush;
  logic                              src_done;

  assign rsp.valid      = out_valid;
  assign rsp.out_bytes  = out_bytes;
  assign rsp.byte_count = out_count;
  assign rsp.last       = out_last;

  assign status.clearing = (state == srae_pkg::BK_CLEAR);

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    acc_next       = acc;
    fill_next      = fill;
    rem_next       = rem;
    raddr_next     = raddr;
    pend_next      = pend;
    out_valid_next = out_valid && !rsp.ready;
    out_bytes_next = out_bytes;
    out_count_next = out_count;
    out_last_next  = out_last;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr;
    mem_wdata      = 8'd0;
    rd_issue       = 1'b0;
    take           = 1'b0;
    flush          = 1'b0;
    src_done       = 1'b0;

    case (state)
      srae_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == srae_pkg::ADDR_W'(srae_pkg::MAP_BYTES - 1)) begin
          state_next = srae_pkg::BK_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      srae_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (head.op)
            srae_pkg::OP_STORE: begin
              if (!head.reply || out_free) begin
                pop       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = head.addr;
                mem_wdata = head.data;
                if (head.reply) begin
                  out_valid_next = 1'b1;
                  out_bytes_next = srae_pkg::OUT_W'(srae_pkg::ANS_WRITE_OK);
                  out_count_next = srae_pkg::COUNT_W'(1);
                  out_last_next  = 1'b1;
                end
              end
            end
            srae_pkg::OP_REPLY: begin
              if (out_free) begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_bytes_next = srae_pkg::OUT_W'(head.data);
                out_count_next = srae_pkg::COUNT_W'(1);
                out_last_next  = 1'b1;
              end
            end
            srae_pkg::OP_READ: begin
              pop         = 1'b1;
              acc_next    = '0;
              acc_next[0] = srae_pkg::ANS_READ;
              fill_next   = srae_pkg::FILL_W'(1);
              rem_next    = head.data;
              raddr_next  = head.addr;
              pend_next   = 1'b0;
              state_next  = srae_pkg::BK_READ;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end

      srae_pkg::BK_READ: begin
        take     = pend && (fill != srae_pkg::FILL_W'(BPR));
        src_done = (rem == 8'd0) && !pend;
        flush    = out_free && ((fill == srae_pkg::FILL_W'(BPR)) || src_done);
        rd_issue = (rem != 8'd0) && (!pend || take);
        if (take) begin
          acc_next[fill[srae_pkg::LANE_W-1:0]] = rd_data;
          fill_next = fill + 1'b1;
        end
        if (rd_issue) begin
          rem_next = rem - 8'd1;
          if (raddr == srae_pkg::ADDR_W'(srae_pkg::MAP_BYTES - 1)) begin
            raddr_next = '0;
          end else begin
            raddr_next = raddr + 1'b1;
          end
        end
        pend_next = rd_issue || (pend && !take);
        if (flush) begin
          out_valid_next = 1'b1;
          out_bytes_next = srae_pkg::OUT_W'(acc);
          out_count_next = srae_pkg::COUNT_W'(fill);
          out_last_next  = src_done;
          acc_next       = '0;
          fill_next      = '0;
          if (src_done) begin
            state_next = srae_pkg::BK_IDLE;
          end
        end
      end

      default: begin
        state_next = srae_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_issue) begin
      rd_data <= map_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srae_pkg::BK_CLEAR;
      clr_addr  <= '0;
      fill      <= '0;
      rem       <= '0;
      raddr     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      fill      <= fill_next;
      rem       <= rem_next;
      raddr     <= raddr_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    acc       <= acc_next;
    out_bytes <= out_bytes_next;
    out_count <= out_count_next;
    out_last  <= out_last_next;
  end

  a_clear_start: assert property (@(posedge clk) rst |=> (state == srae_pkg::BK_CLEAR)
                                                      && (clr_addr == '0))
    else $error("clear pass does not restart after reset");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
                                  (state != srae_pkg::BK_IDLE) |-> !pop)
    else $error("job taken while clearing or reading");
  a_take_flush: assert property (@(posedge clk) disable iff (rst) take |-> !flush)
    else $error("read byte appended in a flush cycle");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
                                 fill <= srae_pkg::FILL_W'(BPR))
    else $error("packing register overfilled");
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
                                (state != srae_pkg::BK_READ) |-> !pend)
    else $error("read data pending outside a burst");

endmodule

`default_nettype wire

>>> src/serial_register_access_engine.sv
// ----------------------------------------------------------------------------
// serial_register_access_engine
// Byte-stream register access engine over a 512-byte map: header parser,
// job queue and executor with the map memory.
// ----------------------------------------------------------------------------
//   channel  dir  payload                           accepted when
//   req      in   kind, rx_byte                     req.valid && req.ready
//   rsp      out  out_bytes, byte_count, last       rsp.valid && rsp.ready
//
// A transaction on req is accepted whenever the 4-entry job queue has room
// and the map is not being cleared. After reset all 512 map bytes are
// cleared; req.ready is low during that pass. Single-byte answers, and
// stores that reply, wait for a free response register. A read of N bytes
// holds the executor until its burst is sent, one map read port access per
// byte. A stalled rsp backs up into the queue and then into req.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_register_access_engine (
  input  wire         clk,
  input  wire         rst,
  srae_req_if.sink    req,
  srae_rsp_if.source  rsp
);

  logic                    push;
  srae_pkg::job_t          push_job;
  logic                    pop;
  logic                    q_valid;
  logic                    q_full;
  srae_pkg::job_t          head;
  srae_pkg::back_status_t  status;

  srae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .q_full   (q_full),
    .status   (status),
    .push     (push),
    .push_job (push_job)
  );

  srae_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head),
    .q_full   (q_full)
  );

  srae_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .status  (status),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
